// File: design/flcts_pkg.sv
// ----------------------------------------------------------------------------
// flcts_pkg
// Shared types and constants for the floor/ceiling texel stepper.
// ----------------------------------------------------------------------------
package flcts_pkg;

  // Fixed datapath widths (set by the 12-bit size registers and Q16.16 inputs)
  localparam int DIV_N   = 44;  // dividend bits of the serial divider
  localparam int DIV_D   = 12;  // divisor bits
  localparam int DIST_W  = 27;  // row distance magnitude
  localparam int OPND_W  = 33;  // ray or plane magnitude
  localparam int ACC_W   = DIST_W + OPND_W;
  localparam int FRAC_W  = 16;
  localparam int ACC_W48 = 48;

  typedef enum logic {
    REQ_ROW = 1'b0,
    REQ_PIX = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_DIR_X  = 3'd2,
    REG_DIR_Y  = 3'd3,
    REG_PLN_X  = 3'd4,
    REG_PLN_Y  = 3'd5,
    REG_POS_X  = 3'd6,
    REG_POS_Y  = 3'd7
  } cfg_reg_t;

  // Product being formed: left ray x/y feed the start point, 2*plane feeds the stride
  typedef enum logic [1:0] {
    SEL_LX  = 2'd0,
    SEL_LY  = 2'd1,
    SEL_PX2 = 2'd2,
    SEL_PY2 = 2'd3
  } op_sel_t;

  typedef enum logic {
    DIV_DIST = 1'b0,
    DIV_PROD = 1'b1
  } div_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DSTART,
    ST_DDIV,
    ST_PP_LO,
    ST_PP_HI,
    ST_ACC,
    ST_WORLD,
    ST_SSTART,
    ST_SDIV
  } state_t;

  typedef struct packed {
    logic     row_take;
    logic     pix_take;
    logic     div_start;
    div_src_t div_src;
    logic     dist_load;
    logic     mul_lo;
    logic     mul_hi;
    logic     acc_add;
    logic     world_load;
    logic     stride_load;
    op_sel_t  sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pix_serve;
    logic div_busy;
  } dp_status_t;

endpackage

// File: design/flcts_div.sv
// ----------------------------------------------------------------------------
// flcts_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module flcts_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [flcts_pkg::DIV_N-1:0]   dividend,
  input  logic [flcts_pkg::DIV_D-1:0]   divisor,
  output logic                          busy,
  output logic [flcts_pkg::DIV_N-1:0]   quotient
);

  localparam int N   = flcts_pkg::DIV_N;
  localparam int D   = flcts_pkg::DIV_D;
  localparam int CW  = $clog2(N + 1);

  logic [CW-1:0] cnt;
  logic [D-1:0]  rem;
  logic [D-1:0]  dsr;
  logic [D:0]    rem_sh;
  logic [D:0]    diff;
  logic          ge;

  assign rem_sh = {rem, quotient[N-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = !diff[D];
  assign busy   = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(N);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[D-1:0] : rem_sh[D-1:0];
      quotient <= {quotient[N-2:0], ge};
    end
  end

endmodule

// File: design/flcts_datapath.sv
// ----------------------------------------------------------------------------
// flcts_datapath
// Config registers, row setup arithmetic, per-pixel stepping and result regs.
// ----------------------------------------------------------------------------
module flcts_datapath #(
  parameter int TEX_SIZE   = 64,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic [10:0]              row,
  input  flcts_pkg::ctrl_cmd_t     cmd,
  output flcts_pkg::dp_status_t    stat,
  output logic [23:0]              floor_addr,
  output logic [23:0]              ceiling_addr,
  output logic [5:0]               tex_x,
  output logic [5:0]               tex_y,
  output logic [10:0]              column,
  output logic                     last_in_row
);

  localparam int TEX_W  = $clog2(TEX_SIZE) + 1;
  localparam int DIST_W = flcts_pkg::DIST_W;
  localparam int OPND_W = flcts_pkg::OPND_W;
  localparam int ACC_W  = flcts_pkg::ACC_W;
  localparam int FRAC_W = flcts_pkg::FRAC_W;
  localparam int DIV_N  = flcts_pkg::DIV_N;
  localparam int DIV_D  = flcts_pkg::DIV_D;
  localparam int W48    = flcts_pkg::ACC_W48;
  localparam int HI_W   = OPND_W - FRAC_W;
  localparam int PP_W   = DIST_W + HI_W;

  // configuration
  logic [11:0] screen_width, screen_height;
  logic [31:0] view_dir_x, view_dir_y, cam_plane_x, cam_plane_y;
  logic [31:0] viewer_pos_x, viewer_pos_y;

  // row state
  logic [10:0] active_row;
  logic        row_valid;
  logic [11:0] next_column;
  logic [W48-1:0] world_x, world_y, stride_x, stride_y;

  // setup scratch
  logic [DIST_W-1:0] dist_mag;
  logic              dist_neg;
  logic [PP_W-1:0]   pp;
  logic [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 12'd640;
      screen_height <= 12'd480;
      view_dir_x    <= 32'h0001_0000;
      view_dir_y    <= '0;
      cam_plane_x   <= '0;
      cam_plane_y   <= 32'd43253;
      viewer_pos_x  <= '0;
      viewer_pos_y  <= '0;
    end else if (cfg_we) begin
      unique case (flcts_pkg::cfg_reg_t'(cfg_index))
        flcts_pkg::REG_WIDTH:  screen_width  <= cfg_data[11:0];
        flcts_pkg::REG_HEIGHT: screen_height <= cfg_data[11:0];
        flcts_pkg::REG_DIR_X:  view_dir_x    <= cfg_data;
        flcts_pkg::REG_DIR_Y:  view_dir_y    <= cfg_data;
        flcts_pkg::REG_PLN_X:  cam_plane_x   <= cfg_data;
        flcts_pkg::REG_PLN_Y:  cam_plane_y   <= cfg_data;
        flcts_pkg::REG_POS_X:  viewer_pos_x  <= cfg_data;
        flcts_pkg::REG_POS_Y:  viewer_pos_y  <= cfg_data;
      endcase
    end
  end

  // clamped screen size
  logic [12:0] w_eff, h_eff;
  assign w_eff = ({1'b0, screen_width} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH)
                                                          : {1'b0, screen_width};
  assign h_eff = ({1'b0, screen_height} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT)
                                                            : {1'b0, screen_height};

  // row offset from the horizon, zero replaced by one
  logic signed [12:0] off;
  logic               off_neg;
  logic [12:0]        off_abs;
  logic [DIV_D-1:0]   off_div;
  assign off     = $signed({2'b00, active_row}) - $signed({2'b00, h_eff[11:1]});
  assign off_neg = off[12];
  assign off_abs = off_neg ? 13'(13'd0 - off) : off;
  assign off_div = (off == '0) ? DIV_D'(1) : off_abs[DIV_D-1:0];

  // operand of the current product
  logic [OPND_W-1:0] opnd, opnd_mag;
  logic              opnd_neg, prod_neg;
  always_comb begin
    unique case (cmd.sel)
      flcts_pkg::SEL_LX:  opnd = {view_dir_x[31], view_dir_x} - {cam_plane_x[31], cam_plane_x};
      flcts_pkg::SEL_LY:  opnd = {view_dir_y[31], view_dir_y} - {cam_plane_y[31], cam_plane_y};
      flcts_pkg::SEL_PX2: opnd = {cam_plane_x, 1'b0};
      flcts_pkg::SEL_PY2: opnd = {cam_plane_y, 1'b0};
    endcase
  end
  assign opnd_neg = opnd[OPND_W-1];
  assign opnd_mag = opnd_neg ? OPND_W'(0 - opnd) : opnd;
  assign prod_neg = dist_neg ^ opnd_neg;

  logic [HI_W-1:0] mul_b;
  assign mul_b = cmd.mul_hi ? opnd_mag[OPND_W-1:FRAC_W]
                            : HI_W'(opnd_mag[FRAC_W-1:0]);

  // divider
  logic [DIV_N-1:0] div_dividend, div_q;
  logic [DIV_D-1:0] div_divisor;
  logic             div_busy;
  logic [DIV_D-1:0] w_div;

  assign w_div = (w_eff == '0) ? DIV_D'(1) : w_eff[DIV_D-1:0];

  always_comb begin
    unique case (cmd.div_src)
      flcts_pkg::DIV_DIST: begin
        div_dividend = DIV_N'({h_eff[11:0], 15'b0});
        div_divisor  = off_div;
      end
      flcts_pkg::DIV_PROD: begin
        div_dividend = acc[ACC_W-1:FRAC_W];
        div_divisor  = w_div;
      end
    endcase
  end

  flcts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // signed results of the setup
  logic [W48-1:0] scaled, scaled_s, pos_s, quo, quo_s;
  assign scaled   = W48'(acc[ACC_W-1:FRAC_W]);
  assign scaled_s = prod_neg ? W48'(0 - scaled) : scaled;
  assign pos_s    = cmd.sel[0] ? {{16{viewer_pos_y[31]}}, viewer_pos_y}
                               : {{16{viewer_pos_x[31]}}, viewer_pos_x};
  assign quo      = W48'(div_q);
  assign quo_s    = prod_neg ? W48'(0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (cmd.dist_load) begin
      dist_mag <= div_q[DIST_W-1:0];
      dist_neg <= off_neg;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      pp <= {{HI_W{1'b0}}, dist_mag} * {{DIST_W{1'b0}}, mul_b};
    end
    if (cmd.mul_hi) begin
      acc <= ACC_W'(pp);
    end else if (cmd.acc_add) begin
      acc <= acc + {pp, {FRAC_W{1'b0}}};
    end
  end

  // texel index from a signed Q32.16 coordinate, fraction truncated toward zero
  function automatic logic [5:0] texel(input logic [W48-1:0] p);
    logic                      neg;
    logic [FRAC_W-1:0]         mag;
    logic [FRAC_W+TEX_W-1:0]   prod;
    logic [TEX_W-1:0]          q;
    logic [15:0]               t;
    logic [15:0]               m;
    neg  = p[W48-1];
    mag  = neg ? FRAC_W'(~p[FRAC_W-1:0] + FRAC_W'(1)) : p[FRAC_W-1:0];
    prod = (FRAC_W+TEX_W)'(mag) * (FRAC_W+TEX_W)'(TEX_SIZE);
    q    = prod[FRAC_W+TEX_W-1:FRAC_W];
    t    = neg ? 16'(16'd0 - 16'(q)) : 16'(q);
    m    = t & 16'(TEX_SIZE - 1);
    return m[5:0];
  endfunction

  // pixel addresses, kept modulo 2^22 before the byte scale
  logic [21:0] row22, w22, x22, crow22, floor_sum, ceil_sum;
  assign row22     = 22'(active_row);
  assign w22       = 22'(w_eff);
  assign x22       = 22'(next_column);
  assign crow22    = 22'(h_eff) - 22'd1 - row22;
  assign floor_sum = 22'(row22 * w22) + x22;
  assign ceil_sum  = 22'(crow22 * w22) + x22;

  assign stat.pix_serve = row_valid && ({1'b0, next_column} < w_eff);
  assign stat.div_busy  = div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_row  <= '0;
      row_valid   <= 1'b0;
      next_column <= '0;
    end else if (cmd.row_take) begin
      active_row  <= row;
      row_valid   <= 1'b1;
      next_column <= '0;
    end else if (cmd.pix_take) begin
      next_column <= next_column + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.world_load) begin
      if (cmd.sel[0]) begin
        world_y <= pos_s + scaled_s;
      end else begin
        world_x <= pos_s + scaled_s;
      end
    end else if (cmd.pix_take) begin
      world_x <= world_x + stride_x;
      world_y <= world_y + stride_y;
    end
    if (cmd.stride_load) begin
      if (cmd.sel[0]) begin
        stride_y <= quo_s;
      end else begin
        stride_x <= quo_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_take) begin
      floor_addr   <= {floor_sum, 2'b00};
      ceiling_addr <= {ceil_sum, 2'b00};
      tex_x        <= texel(world_x);
      tex_y        <= texel(world_y);
      column       <= next_column[10:0];
      last_in_row  <= ({1'b0, next_column} + 13'd1 == w_eff);
    end
  end

endmodule

// File: design/flcts_ctrl.sv
// ----------------------------------------------------------------------------
// flcts_ctrl
// Sequencer for row setup and output register handshake.
// ----------------------------------------------------------------------------
module flcts_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   req_type,
  input  logic                   out_ready,
  input  flcts_pkg::dp_status_t  stat,
  output logic                   in_ready,
  output logic                   out_valid,
  output flcts_pkg::ctrl_cmd_t   cmd
);

  flcts_pkg::state_t  state, state_next;
  flcts_pkg::op_sel_t sel, sel_next;
  logic               out_valid_next;
  logic               accept;

  assign in_ready = (state == flcts_pkg::ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= flcts_pkg::ST_IDLE;
      sel       <= flcts_pkg::SEL_LX;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    unique case (state)
      flcts_pkg::ST_IDLE: begin
        if (accept && (req_type == flcts_pkg::REQ_ROW)) state_next = flcts_pkg::ST_DSTART;
      end
      flcts_pkg::ST_DSTART: state_next = flcts_pkg::ST_DDIV;
      flcts_pkg::ST_DDIV: begin
        if (!stat.div_busy) begin
          state_next = flcts_pkg::ST_PP_LO;
          sel_next   = flcts_pkg::SEL_LX;
        end
      end
      flcts_pkg::ST_PP_LO: state_next = flcts_pkg::ST_PP_HI;
      flcts_pkg::ST_PP_HI: state_next = flcts_pkg::ST_ACC;
      flcts_pkg::ST_ACC: begin
        state_next = sel[1] ? flcts_pkg::ST_SSTART : flcts_pkg::ST_WORLD;
      end
      flcts_pkg::ST_WORLD: begin
        state_next = flcts_pkg::ST_PP_LO;
        sel_next   = flcts_pkg::op_sel_t'(sel + 2'd1);
      end
      flcts_pkg::ST_SSTART: state_next = flcts_pkg::ST_SDIV;
      flcts_pkg::ST_SDIV: begin
        if (!stat.div_busy) begin
          if (sel == flcts_pkg::SEL_PY2) begin
            state_next = flcts_pkg::ST_IDLE;
          end else begin
            state_next = flcts_pkg::ST_PP_LO;
            sel_next   = flcts_pkg::op_sel_t'(sel + 2'd1);
          end
        end
      end
      default: state_next = flcts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.sel     = sel;
    cmd.div_src = flcts_pkg::DIV_DIST;
    unique case (state)
      flcts_pkg::ST_IDLE: begin
        cmd.row_take = accept && (req_type == flcts_pkg::REQ_ROW);
        cmd.pix_take = accept && (req_type == flcts_pkg::REQ_PIX) && stat.pix_serve;
      end
      flcts_pkg::ST_DSTART: cmd.div_start = 1'b1;
      flcts_pkg::ST_DDIV:   cmd.dist_load = !stat.div_busy;
      flcts_pkg::ST_PP_LO:  cmd.mul_lo    = 1'b1;
      flcts_pkg::ST_PP_HI:  cmd.mul_hi    = 1'b1;
      flcts_pkg::ST_ACC:    cmd.acc_add   = 1'b1;
      flcts_pkg::ST_WORLD:  cmd.world_load = 1'b1;
      flcts_pkg::ST_SSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = flcts_pkg::DIV_PROD;
      end
      flcts_pkg::ST_SDIV: begin
        cmd.div_src     = flcts_pkg::DIV_PROD;
        cmd.stride_load = !stat.div_busy;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.pix_take) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  a_ready_no_div: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.div_busy)
    else $error("input ready during row setup");

  a_pix_result: assert property (@(posedge clk) disable iff (rst)
    cmd.pix_take |=> out_valid)
    else $error("served pixel lost its result");

  a_row_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type == flcts_pkg::REQ_ROW)) |=> (!in_ready && !out_valid_next) || !in_ready)
    else $error("row start did not block input");
`endif

endmodule

// File: design/floor_ceiling_texel_stepper_unit.sv
// ----------------------------------------------------------------------------
// floor_ceiling_texel_stepper_unit
// Floor/ceiling raycaster stepper: row setup and per-pixel texel stepping.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): req_type 0 starts a row (row field used),
// req_type 1 asks for the next pixel of the current row.
// Output channel (out_valid/out_ready): one transfer per served pixel with the
// floor and mirrored ceiling byte addresses, texel indices, column and a
// last-pixel flag. Pixels past the row end or before any row start are taken
// and give no transfer.
// Pixel requests: one per cycle unless the output stalls; result registered.
// Row start: the block holds in_ready low while the bit-serial divider runs
// three times (distance, stride x, stride y) and four two-part 27x17
// multiplies are formed.
// Config writes (cfg_we/cfg_index/cfg_data) take effect at once; issue them
// only while the block is idle.
// Reset (rst, synchronous) restores the default screen and camera registers
// and clears the row state; the output register empties.
// If the receiver stalls, the pending result holds and one more pixel is
// taken only when the register drains in the same cycle.
// ----------------------------------------------------------------------------
module floor_ceiling_texel_stepper_unit #(
  parameter int TEX_SIZE   = 64,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [10:0] row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] floor_addr,
  output logic [23:0] ceiling_addr,
  output logic [5:0]  tex_x,
  output logic [5:0]  tex_y,
  output logic [10:0] column,
  output logic        last_in_row
);

  flcts_pkg::ctrl_cmd_t  cmd;
  flcts_pkg::dp_status_t stat;

  flcts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  flcts_datapath #(
    .TEX_SIZE   (TEX_SIZE),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .row          (row),
    .cmd          (cmd),
    .stat         (stat),
    .floor_addr   (floor_addr),
    .ceiling_addr (ceiling_addr),
    .tex_x        (tex_x),
    .tex_y        (tex_y),
    .column       (column),
    .last_in_row  (last_in_row)
  );

endmodule
